[sv/ucm_pkg.sv]
// ucm_pkg: shared types and constants for the upgma cluster merge block
// no dependencies; compiled first
package ucm_pkg;

    localparam int IDX_BITS        = 4;
    localparam int DIST_FIELD_BITS = 32;
    localparam int SIZE_BITS       = 5;
    localparam int LEAF_BITS       = 5;
    localparam int APB_ADDR_BITS   = 3;
    localparam int APB_DATA_BITS   = 32;

    localparam logic [LEAF_BITS-1:0] LEAF_RESET = 5'd16;

    // register index, taken from paddr above the byte offset
    localparam logic [0:0] REG_LEAF_COUNT = 1'b0;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INIT,
        ST_SRCH_INIT,
        ST_SRCH,
        ST_SRCH_DRAIN,
        ST_SIZE1,
        ST_SIZE2,
        ST_MRG_CHK,
        ST_MRG_RD2,
        ST_MRG_MUL,
        ST_MRG_SUM,
        ST_DIV,
        ST_MRG_WR,
        ST_RM_INIT,
        ST_RM_RD,
        ST_RM_WR,
        ST_SZ_UPD,
        ST_EMIT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_RUN_INIT,
        OP_SRCH_INIT,
        OP_SRCH_RD,
        OP_SIZE1,
        OP_SIZE2,
        OP_MRG_SKIP,
        OP_MRG_RD1,
        OP_MRG_RD2,
        OP_MRG_MUL,
        OP_MRG_SUM,
        OP_DIV_STEP,
        OP_MRG_WR,
        OP_RM_INIT,
        OP_RM_RD,
        OP_RM_WR,
        OP_SZ_UPD,
        OP_EMIT
    } t_op;

    typedef struct packed {
        logic n_small;
        logic srch_last;
        logic k_end;
        logic k_skip;
        logic div_last;
        logic rm_end;
        logic n_one;
        logic out_free;
    } t_status;

endpackage

[sv/ucm_if.sv]
// ucm_if: valid/ready channel interfaces for load items and merge results
// field widths from ucm_pkg
interface ucm_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [ucm_pkg::IDX_BITS-1:0]         row;
    logic [ucm_pkg::IDX_BITS-1:0]         col;
    logic [ucm_pkg::DIST_FIELD_BITS-1:0]  dist_req;
    logic                                 last_entry;

    modport source(output valid, row, col, dist_req, last_entry, input ready);
    modport sink(input valid, row, col, dist_req, last_entry, output ready);
endinterface

interface ucm_res_if;
    logic                                 valid;
    logic                                 ready;
    logic [ucm_pkg::IDX_BITS-1:0]         kept_index;
    logic [ucm_pkg::IDX_BITS-1:0]         removed_index;
    logic [ucm_pkg::DIST_FIELD_BITS-1:0]  merge_dist;
    logic [ucm_pkg::SIZE_BITS-1:0]        merged_size;
    logic                                 last_merge;

    modport source(output valid, kept_index, removed_index, merge_dist, merged_size,
                   last_merge, input ready);
    modport sink(input valid, kept_index, removed_index, merge_dist, merged_size,
                 last_merge, output ready);
endinterface

[sv/ucm_ram.sv]
// ucm_ram: generic single write, single read ram with registered read data
// no dependencies
module ucm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/ucm_ctrl.sv]
// ucm_ctrl: sequencer for load, search, merge, removal and result steps
// depends on ucm_pkg (state, command and status types)
module ucm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    input  ucm_pkg::t_status i_status,
    output logic             o_in_ready,
    output ucm_pkg::t_op     o_op
);

    ucm_pkg::t_state r_state;
    ucm_pkg::t_state n_state;
    logic            w_fire;

    assign o_in_ready = (r_state == ucm_pkg::ST_IDLE);
    assign w_fire     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ucm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ucm_pkg::ST_IDLE: begin
                if (w_fire && i_in_last) n_state = ucm_pkg::ST_INIT;
            end
            ucm_pkg::ST_INIT: begin
                n_state = i_status.n_small ? ucm_pkg::ST_IDLE : ucm_pkg::ST_SRCH_INIT;
            end
            ucm_pkg::ST_SRCH_INIT: n_state = ucm_pkg::ST_SRCH;
            ucm_pkg::ST_SRCH: begin
                if (i_status.srch_last) n_state = ucm_pkg::ST_SRCH_DRAIN;
            end
            ucm_pkg::ST_SRCH_DRAIN: n_state = ucm_pkg::ST_SIZE1;
            ucm_pkg::ST_SIZE1:      n_state = ucm_pkg::ST_SIZE2;
            ucm_pkg::ST_SIZE2:      n_state = ucm_pkg::ST_MRG_CHK;
            ucm_pkg::ST_MRG_CHK: begin
                if (i_status.k_end) begin
                    n_state = ucm_pkg::ST_RM_INIT;
                end else if (!i_status.k_skip) begin
                    n_state = ucm_pkg::ST_MRG_RD2;
                end
            end
            ucm_pkg::ST_MRG_RD2: n_state = ucm_pkg::ST_MRG_MUL;
            ucm_pkg::ST_MRG_MUL: n_state = ucm_pkg::ST_MRG_SUM;
            ucm_pkg::ST_MRG_SUM: n_state = ucm_pkg::ST_DIV;
            ucm_pkg::ST_DIV: begin
                if (i_status.div_last) n_state = ucm_pkg::ST_MRG_WR;
            end
            ucm_pkg::ST_MRG_WR:  n_state = ucm_pkg::ST_MRG_CHK;
            ucm_pkg::ST_RM_INIT: n_state = ucm_pkg::ST_RM_RD;
            ucm_pkg::ST_RM_RD: begin
                n_state = i_status.rm_end ? ucm_pkg::ST_SZ_UPD : ucm_pkg::ST_RM_WR;
            end
            ucm_pkg::ST_RM_WR:  n_state = ucm_pkg::ST_RM_RD;
            ucm_pkg::ST_SZ_UPD: n_state = ucm_pkg::ST_EMIT;
            ucm_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    n_state = i_status.n_one ? ucm_pkg::ST_IDLE : ucm_pkg::ST_SRCH_INIT;
                end
            end
            default: n_state = ucm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_op = ucm_pkg::OP_NONE;
        case (r_state)
            ucm_pkg::ST_IDLE:      o_op = w_fire ? ucm_pkg::OP_LOAD : ucm_pkg::OP_NONE;
            ucm_pkg::ST_INIT:      o_op = ucm_pkg::OP_RUN_INIT;
            ucm_pkg::ST_SRCH_INIT: o_op = ucm_pkg::OP_SRCH_INIT;
            ucm_pkg::ST_SRCH:      o_op = ucm_pkg::OP_SRCH_RD;
            ucm_pkg::ST_SIZE1:     o_op = ucm_pkg::OP_SIZE1;
            ucm_pkg::ST_SIZE2:     o_op = ucm_pkg::OP_SIZE2;
            ucm_pkg::ST_MRG_CHK: begin
                if (i_status.k_end) begin
                    o_op = ucm_pkg::OP_NONE;
                end else if (i_status.k_skip) begin
                    o_op = ucm_pkg::OP_MRG_SKIP;
                end else begin
                    o_op = ucm_pkg::OP_MRG_RD1;
                end
            end
            ucm_pkg::ST_MRG_RD2: o_op = ucm_pkg::OP_MRG_RD2;
            ucm_pkg::ST_MRG_MUL: o_op = ucm_pkg::OP_MRG_MUL;
            ucm_pkg::ST_MRG_SUM: o_op = ucm_pkg::OP_MRG_SUM;
            ucm_pkg::ST_DIV:     o_op = ucm_pkg::OP_DIV_STEP;
            ucm_pkg::ST_MRG_WR:  o_op = ucm_pkg::OP_MRG_WR;
            ucm_pkg::ST_RM_INIT: o_op = ucm_pkg::OP_RM_INIT;
            ucm_pkg::ST_RM_RD:   o_op = i_status.rm_end ? ucm_pkg::OP_NONE : ucm_pkg::OP_RM_RD;
            ucm_pkg::ST_RM_WR:   o_op = ucm_pkg::OP_RM_WR;
            ucm_pkg::ST_SZ_UPD:  o_op = ucm_pkg::OP_SZ_UPD;
            ucm_pkg::ST_EMIT:    o_op = i_status.out_free ? ucm_pkg::OP_EMIT : ucm_pkg::OP_NONE;
            default:             o_op = ucm_pkg::OP_NONE;
        endcase
    end

endmodule

[sv/ucm_dp.sv]
// ucm_dp: distance store, minimum search, weighted average divider, index removal
// depends on ucm_pkg and ucm_ram
module ucm_dp #(
    parameter int MAX_LEAVES = 16,
    parameter int DIST_BITS  = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ucm_pkg::t_op                         i_op,
    input  logic [ucm_pkg::LEAF_BITS-1:0]        i_leaf_count,
    input  logic [ucm_pkg::IDX_BITS-1:0]         i_row,
    input  logic [ucm_pkg::IDX_BITS-1:0]         i_col,
    input  logic [ucm_pkg::DIST_FIELD_BITS-1:0]  i_dist,
    input  logic                                 i_out_ready,
    output ucm_pkg::t_status                     o_status,
    output logic                                 o_out_valid,
    output logic [ucm_pkg::IDX_BITS-1:0]         o_kept,
    output logic [ucm_pkg::IDX_BITS-1:0]         o_removed,
    output logic [ucm_pkg::DIST_FIELD_BITS-1:0]  o_dist,
    output logic [ucm_pkg::SIZE_BITS-1:0]        o_size,
    output logic                                 o_last
);

    localparam int IW    = $clog2(MAX_LEAVES);
    localparam int NW    = $clog2(MAX_LEAVES + 1);
    localparam int SW    = NW;
    localparam int DEPTH = MAX_LEAVES * MAX_LEAVES;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = DIST_BITS + SW;
    localparam int QW    = DIST_BITS + SW + 1;
    localparam int CW    = $clog2(QW);

    // store keeps only the entry with the lower index first
    function automatic logic [AW-1:0] f_addr(input logic [IW-1:0] a, input logic [IW-1:0] b);
        logic [IW-1:0] lo;
        logic [IW-1:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        return AW'(AW'(lo) * AW'(MAX_LEAVES) + AW'(hi));
    endfunction

    logic [NW-1:0]        r_n;
    logic [NW-1:0]        r_a;
    logic [NW-1:0]        r_b;
    logic [NW-1:0]        r_k;
    logic [IW-1:0]        r_bi;
    logic [IW-1:0]        r_bj;
    logic [DIST_BITS-1:0] r_best;
    logic                 r_rv;
    logic                 r_rfirst;
    logic [IW-1:0]        r_ra;
    logic [IW-1:0]        r_rb;
    logic [SW-1:0]        r_sz [MAX_LEAVES];
    logic [SW-1:0]        n_sz [MAX_LEAVES];
    logic [SW-1:0]        r_s1;
    logic [SW-1:0]        r_s2;
    logic [PW-1:0]        r_p1;
    logic [PW-1:0]        r_p2;
    logic [QW-1:0]        r_num;
    logic [SW-1:0]        r_rem;
    logic [CW-1:0]        r_dcnt;

    logic                 r_ovalid;
    logic [ucm_pkg::IDX_BITS-1:0]        r_okept;
    logic [ucm_pkg::IDX_BITS-1:0]        r_orem;
    logic [ucm_pkg::DIST_FIELD_BITS-1:0] r_odist;
    logic [ucm_pkg::SIZE_BITS-1:0]       r_osize;
    logic                                r_olast;

    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [DIST_BITS-1:0] w_wdata;
    logic [AW-1:0]        w_raddr;
    logic [DIST_BITS-1:0] w_rdata;
    logic                 w_load_ok;
    logic [SW-1:0]        w_sum_s;
    logic [SW:0]          w_trial;
    logic                 w_ge;
    logic [NW-1:0]        w_sa;
    logic [NW-1:0]        w_a_next;
    logic [NW-1:0]        w_rm_b_next;
    logic [NW-1:0]        w_n_init;

    assign w_load_ok = (i_row != i_col) && (int'(i_row) < MAX_LEAVES)
                       && (int'(i_col) < MAX_LEAVES);
    assign w_sum_s   = SW'(r_s1 + r_s2);
    assign w_trial   = {r_rem, r_num[QW-1]};
    assign w_ge      = (w_trial >= {1'b0, w_sum_s});
    assign w_sa      = (r_a >= NW'(r_bj)) ? NW'(r_a + 1'b1) : r_a;
    assign w_a_next  = NW'(r_a + 1'b1);
    assign w_rm_b_next = (int'(r_a) + 3 > int'(r_bj)) ? NW'(r_a + 2'd3 - 2'd1)
                                                       : NW'(r_bj);
    assign w_n_init  = (int'(i_leaf_count) > MAX_LEAVES) ? NW'(MAX_LEAVES)
                                                          : NW'(i_leaf_count);

    ucm_ram #(
        .WIDTH(DIST_BITS),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_comb begin
        w_we    = 1'b0;
        w_waddr = f_addr(r_bi, r_k[IW-1:0]);
        w_wdata = r_num[DIST_BITS-1:0];
        case (i_op)
            ucm_pkg::OP_LOAD: begin
                w_we    = w_load_ok;
                w_waddr = f_addr(IW'(i_row), IW'(i_col));
                w_wdata = DIST_BITS'(i_dist);
            end
            ucm_pkg::OP_MRG_WR: begin
                w_we = 1'b1;
            end
            ucm_pkg::OP_RM_WR: begin
                w_we    = 1'b1;
                w_waddr = f_addr(r_a[IW-1:0], r_b[IW-1:0]);
                w_wdata = w_rdata;
            end
            default: w_we = 1'b0;
        endcase
    end

    always_comb begin
        w_raddr = f_addr(r_a[IW-1:0], r_b[IW-1:0]);
        case (i_op)
            ucm_pkg::OP_MRG_RD1: w_raddr = f_addr(r_bi, r_k[IW-1:0]);
            ucm_pkg::OP_MRG_RD2: w_raddr = f_addr(r_bj, r_k[IW-1:0]);
            ucm_pkg::OP_RM_RD:   w_raddr = f_addr(w_sa[IW-1:0], IW'(r_b + 1'b1));
            default:             w_raddr = f_addr(r_a[IW-1:0], r_b[IW-1:0]);
        endcase
    end

    // merged cluster takes both sizes, later ones shift down, the freed slot is a leaf
    always_comb begin
        for (int k = 0; k < MAX_LEAVES; k++) begin
            n_sz[k] = r_sz[k];
            if (k + 1 < MAX_LEAVES) begin
                if (k >= int'(r_bj) && k + 1 < int'(r_n)) n_sz[k] = r_sz[k + 1];
            end
            if (k == int'(r_n) - 1) begin
                n_sz[k] = SW'(1);
            end else if (k == int'(r_bi)) begin
                n_sz[k] = w_sum_s;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv     <= 1'b0;
            r_ovalid <= 1'b0;
            r_n      <= '0;
        end else begin
            r_rv <= (i_op == ucm_pkg::OP_SRCH_RD);
            // a new result may replace one that leaves in the same cycle
            if (i_op == ucm_pkg::OP_EMIT) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end

            // compare uses the read data in the cycle after the read
            if (r_rv && (r_rfirst || (w_rdata < r_best))) begin
                r_best <= w_rdata;
                r_bi   <= r_ra;
                r_bj   <= r_rb;
            end

            case (i_op)
                ucm_pkg::OP_RUN_INIT: begin
                    r_n <= w_n_init;
                    for (int k = 0; k < MAX_LEAVES; k++) r_sz[k] <= SW'(1);
                end
                ucm_pkg::OP_SRCH_INIT: begin
                    r_a <= '0;
                    r_b <= NW'(1);
                end
                ucm_pkg::OP_SRCH_RD: begin
                    r_ra     <= r_a[IW-1:0];
                    r_rb     <= r_b[IW-1:0];
                    r_rfirst <= (r_a == '0) && (r_b == NW'(1));
                    if (int'(r_b) + 1 < int'(r_n)) begin
                        r_b <= NW'(r_b + 1'b1);
                    end else begin
                        r_a <= w_a_next;
                        r_b <= NW'(r_a + 2'd2);
                    end
                end
                ucm_pkg::OP_SIZE1: r_s1 <= r_sz[r_bi];
                ucm_pkg::OP_SIZE2: begin
                    r_s2 <= r_sz[r_bj];
                    r_k  <= '0;
                end
                ucm_pkg::OP_MRG_SKIP: r_k <= NW'(r_k + 1'b1);
                ucm_pkg::OP_MRG_RD2:  r_p1 <= PW'(w_rdata) * PW'(r_s1);
                ucm_pkg::OP_MRG_MUL:  r_p2 <= PW'(w_rdata) * PW'(r_s2);
                ucm_pkg::OP_MRG_SUM: begin
                    r_num  <= QW'(r_p1) + QW'(r_p2);
                    r_rem  <= '0;
                    r_dcnt <= '0;
                end
                ucm_pkg::OP_DIV_STEP: begin
                    r_rem  <= w_ge ? SW'(w_trial - {1'b0, w_sum_s}) : SW'(w_trial);
                    r_num  <= {r_num[QW-2:0], w_ge};
                    r_dcnt <= CW'(r_dcnt + 1'b1);
                end
                ucm_pkg::OP_MRG_WR: r_k <= NW'(r_k + 1'b1);
                ucm_pkg::OP_RM_INIT: begin
                    r_a <= '0;
                    r_b <= NW'(r_bj);
                end
                ucm_pkg::OP_RM_WR: begin
                    if (int'(r_b) + 2 < int'(r_n)) begin
                        r_b <= NW'(r_b + 1'b1);
                    end else begin
                        r_a <= w_a_next;
                        r_b <= w_rm_b_next;
                    end
                end
                ucm_pkg::OP_SZ_UPD: begin
                    r_sz <= n_sz;
                    r_n  <= NW'(r_n - 1'b1);
                end
                ucm_pkg::OP_EMIT: begin
                    r_okept  <= ucm_pkg::IDX_BITS'(r_bi);
                    r_orem   <= ucm_pkg::IDX_BITS'(r_bj);
                    r_odist  <= ucm_pkg::DIST_FIELD_BITS'(r_best);
                    r_osize  <= ucm_pkg::SIZE_BITS'(w_sum_s);
                    r_olast  <= (r_n == NW'(1));
                end
                default: r_n <= r_n;
            endcase
        end
    end

    always_comb begin
        o_status.n_small   = (i_leaf_count < ucm_pkg::LEAF_BITS'(2));
        o_status.srch_last = (int'(r_b) + 1 == int'(r_n)) && (int'(r_a) + 2 == int'(r_n));
        o_status.k_end     = (r_k >= r_n);
        o_status.k_skip    = (r_k == NW'(r_bi)) || (r_k == NW'(r_bj));
        o_status.div_last  = (int'(r_dcnt) == QW - 1);
        o_status.rm_end    = (int'(r_b) + 2 > int'(r_n));
        o_status.n_one     = (r_n == NW'(1));
        o_status.out_free  = !r_ovalid || i_out_ready;
    end

    assign o_out_valid = r_ovalid;
    assign o_kept      = r_okept;
    assign o_removed   = r_orem;
    assign o_dist      = r_odist;
    assign o_size      = r_osize;
    assign o_last      = r_olast;

endmodule

[sv/upgma_cluster_merge.sv]
// UPGMA clustering over a loaded upper-triangle distance matrix. Load items are taken
// while the block is idle. The item marked last starts a run over leaf_count leaves,
// at most MAX_LEAVES; input is held off until the run ends. For each merge the run
// scans the store for the minimum through its single read port, forms the weighted
// averages with a bit-serial divider, and squeezes the removed index out of the store.
// A result waits in an output register.
// depends on ucm_pkg, ucm_if, ucm_ctrl, ucm_dp
module upgma_cluster_merge #(
    parameter int MAX_LEAVES = 16,
    parameter int DIST_BITS  = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    ucm_req_if.sink                            i_req,
    ucm_res_if.source                          o_res,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ucm_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [ucm_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [ucm_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready
);

    logic [ucm_pkg::LEAF_BITS-1:0] r_leaf_count;
    logic [0:0]                    w_reg_idx;
    ucm_pkg::t_op                  w_op;
    ucm_pkg::t_status              w_status;

    assign w_reg_idx = paddr[ucm_pkg::APB_ADDR_BITS-1:2];
    assign pready    = 1'b1;
    assign prdata    = (w_reg_idx == ucm_pkg::REG_LEAF_COUNT)
                       ? ucm_pkg::APB_DATA_BITS'(r_leaf_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leaf_count <= ucm_pkg::LEAF_RESET;
        end else if (psel && penable && pwrite && (w_reg_idx == ucm_pkg::REG_LEAF_COUNT)) begin
            r_leaf_count <= pwdata[ucm_pkg::LEAF_BITS-1:0];
        end
    end

    ucm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_req.valid),
        .i_in_last (i_req.last_entry),
        .i_status  (w_status),
        .o_in_ready(i_req.ready),
        .o_op      (w_op)
    );

    ucm_dp #(
        .MAX_LEAVES(MAX_LEAVES),
        .DIST_BITS (DIST_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_op),
        .i_leaf_count(r_leaf_count),
        .i_row       (i_req.row),
        .i_col       (i_req.col),
        .i_dist      (i_req.dist_req),
        .i_out_ready (o_res.ready),
        .o_status    (w_status),
        .o_out_valid (o_res.valid),
        .o_kept      (o_res.kept_index),
        .o_removed   (o_res.removed_index),
        .o_dist      (o_res.merge_dist),
        .o_size      (o_res.merged_size),
        .o_last      (o_res.last_merge)
    );

`ifndef ASSERT_OFF
    // a run of two or more leaves holds off the next load
    a_run_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && i_req.last_entry && (r_leaf_count >= 5'd2))
        |=> !i_req.ready)
        else $error("input taken while a run was starting");

    a_kept_below_removed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> ((MAX_LEAVES > 16) || (o_res.kept_index < o_res.removed_index)))
        else $error("merge result with kept index not below removed index");

    a_merged_size_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> ((MAX_LEAVES > 16) || (o_res.merged_size >= 5'd2)))
        else $error("merge result with fewer than two leaves");
`endif

endmodule

[bench/upgma_cluster_merge_checker.sv]
// upgma_cluster_merge_checker: watches the load and merge channels and the register port,
// predicts every merge result and compares it field by field
// depends on ucm_pkg and ucm_if
module upgma_cluster_merge_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    ucm_req_if                                req,
    ucm_res_if                                res,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic                              pready,
    input  logic [ucm_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [ucm_pkg::APB_DATA_BITS-1:0] pwdata,
    output int                                o_errors,
    output int                                o_pending,
    output int                                o_merges
);
    import ucm_pkg::*;

    localparam int LEAVES = 16;

    typedef struct packed {
        logic [IDX_BITS-1:0]        kept;
        logic [IDX_BITS-1:0]        removed;
        logic [DIST_FIELD_BITS-1:0] mdist;
        logic [SIZE_BITS-1:0]       size;
        logic                       last;
    } merge_t;

    merge_t                     merge_q[$];
    logic [DIST_FIELD_BITS-1:0] dist_mat[LEAVES][LEAVES];
    int                         clus_size[LEAVES];
    logic [LEAF_BITS-1:0]       leaf_reg;

    task automatic cluster_leaves();
        int          n;
        int          bi;
        int          bj;
        int          sa;
        int          sb;
        logic [31:0] best;
        logic [63:0] s1;
        logic [63:0] s2;
        merge_t      m;
        n = (leaf_reg > LEAVES) ? LEAVES : int'(leaf_reg);
        for (int k = 0; k < LEAVES; k++) clus_size[k] = 1;
        while (n > 1) begin
            bi = 0;
            bj = 1;
            best = dist_mat[0][1];
            for (int a = 0; a < n; a++)
                for (int b = a + 1; b < n; b++)
                    if (dist_mat[a][b] < best) begin
                        best = dist_mat[a][b];
                        bi = a;
                        bj = b;
                    end
            s1 = clus_size[bi];
            s2 = clus_size[bj];
            for (int k = 0; k < n; k++) begin
                if (k != bi && k != bj) begin
                    dist_mat[bi][k] = 32'((s1 * dist_mat[bi][k] + s2 * dist_mat[bj][k])
                                          / (s1 + s2));
                    dist_mat[k][bi] = dist_mat[bi][k];
                end
            end
            clus_size[bi] = int'(s1 + s2);
            // squeeze out the removed index, sources never behind targets
            for (int a = 0; a + 1 < n; a++) begin
                sa = (a >= bj) ? a + 1 : a;
                for (int b = 0; b + 1 < n; b++) begin
                    sb = (b >= bj) ? b + 1 : b;
                    dist_mat[a][b] = dist_mat[sa][sb];
                end
            end
            for (int k = bj; k + 1 < n; k++) clus_size[k] = clus_size[k + 1];
            clus_size[n - 1] = 1;
            n--;
            m.kept    = IDX_BITS'(bi);
            m.removed = IDX_BITS'(bj);
            m.mdist   = best;
            m.size    = SIZE_BITS'(s1 + s2);
            m.last    = (n == 1);
            merge_q = {merge_q, m};
        end
    endtask

    always @(posedge i_clk) begin
        merge_t exp_m;
        if (!i_rst_n) begin
            leaf_reg = LEAF_RESET;
            merge_q.delete();
            o_errors  <= 0;
            o_merges  <= 0;
        end else begin
            if (psel && penable && pwrite && pready
                && paddr[APB_ADDR_BITS-1:2] == REG_LEAF_COUNT)
                leaf_reg = pwdata[LEAF_BITS-1:0];
            if (req.valid && req.ready) begin
                if (req.row != req.col) begin
                    dist_mat[req.row][req.col] = req.dist_req;
                    dist_mat[req.col][req.row] = req.dist_req;
                end
                if (req.last_entry) cluster_leaves();
            end
            if (res.valid && res.ready) begin
                o_merges <= o_merges + 1;
                if (merge_q.size() == 0) begin
                    $error("merge transfer with nothing expected");
                    o_errors <= o_errors + 1;
                end else begin
                    exp_m = merge_q.pop_front();
                    if (res.kept_index !== exp_m.kept ||
                        res.removed_index !== exp_m.removed ||
                        res.merge_dist !== exp_m.mdist ||
                        res.merged_size !== exp_m.size ||
                        res.last_merge !== exp_m.last)
                        o_errors <= o_errors + 1;
                    if (res.kept_index !== exp_m.kept)
                        $error("kept_index expected %0d got %0d", exp_m.kept, res.kept_index);
                    if (res.removed_index !== exp_m.removed)
                        $error("removed_index expected %0d got %0d",
                               exp_m.removed, res.removed_index);
                    if (res.merge_dist !== exp_m.mdist)
                        $error("merge_dist expected %h got %h", exp_m.mdist, res.merge_dist);
                    if (res.merged_size !== exp_m.size)
                        $error("merged_size expected %0d got %0d",
                               exp_m.size, res.merged_size);
                    if (res.last_merge !== exp_m.last)
                        $error("last_merge expected %0d got %0d", exp_m.last, res.last_merge);
                end
            end
        end
        o_pending <= merge_q.size();
    end
endmodule

[bench/upgma_cluster_merge_test.sv]
// upgma_cluster_merge_test: clock, reset, register writes and load stimulus for the
// clustering block; depends on ucm_pkg, ucm_if and upgma_cluster_merge_checker
module upgma_cluster_merge_test;
    import ucm_pkg::*;

    localparam int LIMIT = 2000000;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_ADDR_BITS-1:0]  paddr;
    logic [APB_DATA_BITS-1:0]  pwdata;
    logic [APB_DATA_BITS-1:0]  prdata;
    logic                      pready;
    int                        errors;
    int                        pending;
    int                        merges;
    int                        idle_pct = 0;
    int                        stall_pct = 0;
    bit                        long_hold = 1'b0;
    int                        loads = 0;
    int                        runs = 0;
    int                        cycles = 0;

    ucm_req_if req_ch ();
    ucm_res_if res_ch ();

    upgma_cluster_merge dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    upgma_cluster_merge_checker checker_inst (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .o_errors  (errors),
        .o_pending (pending),
        .o_merges  (merges)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("[upgma_cluster_merge] ERROR");
            $finish;
        end
    end

    // merge receiver, with a long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (long_hold) begin
            res_ch.ready <= 1'b0;
            repeat (400) @(posedge i_clk);
            long_hold = 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic write_leaf(input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_LEAF_COUNT, 2'b00};
        pwdata  <= APB_DATA_BITS'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_load(input int r, input int c, input logic [31:0] d, input bit last);
        while ($urandom_range(99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.row        <= IDX_BITS'(r);
        req_ch.col        <= IDX_BITS'(c);
        req_ch.dist_req   <= d;
        req_ch.last_entry <= last;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        if (r != c) loads++;
        if (last) runs++;
    endtask

    // drop valid and wait for every merge of the run, then let the block settle
    task automatic drain_run();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_dist(input int dmode);
        case (dmode)
            0:       return $urandom();
            1:       return 32'($urandom_range(3));
            default: return 32'hFFFF_FFFF - 32'($urandom_range(3));
        endcase
    endfunction

    // loads every pair of up to 16 leaves in shuffled order, last flag on the final one
    task automatic load_matrix(input int leaf, input int dmode);
        int pairs[$];
        int n;
        int j;
        int t;
        n = (leaf > 16) ? 16 : ((leaf < 2) ? 2 : leaf);
        for (int a = 0; a < n; a++)
            for (int b = a + 1; b < n; b++) pairs = {pairs, a * 16 + b};
        if (leaf < 2) pairs = '{pairs[0]};
        for (int i = pairs.size() - 1; i > 0; i--) begin
            j = $urandom_range(i);
            t = pairs[i];
            pairs[i] = pairs[j];
            pairs[j] = t;
        end
        foreach (pairs[i]) begin
            if ($urandom_range(9) == 0) begin
                t = $urandom_range(15);
                send_load(t, t, $urandom(), 1'b0);
            end
            if ($urandom_range(1))
                send_load(pairs[i] / 16, pairs[i] % 16, pick_dist(dmode),
                          i == pairs.size() - 1);
            else
                send_load(pairs[i] % 16, pairs[i] / 16, pick_dist(dmode),
                          i == pairs.size() - 1);
        end
    endtask

    initial begin
        int leaf;
        int r;
        int set_no;
        i_rst_n           <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.row        <= '0;
        req_ch.col        <= '0;
        req_ch.dist_req   <= '0;
        req_ch.last_entry <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extreme distances, ties, zero distances, runs with no merges
        write_leaf(2);
        send_load(0, 1, 32'h0, 1'b0);
        send_load(1, 0, 32'hFFFF_FFFF, 1'b1);
        drain_run();
        write_leaf(3);
        send_load(15, 15, 32'hFFFF_FFFF, 1'b0);
        send_load(0, 1, 32'd5, 1'b0);
        send_load(2, 0, 32'd5, 1'b0);
        send_load(1, 2, 32'd5, 1'b1);
        drain_run();
        write_leaf(0);
        send_load(0, 1, 32'd9, 1'b1);
        drain_run();
        write_leaf(1);
        send_load(3, 4, 32'd7, 1'b1);
        drain_run();
        write_leaf(4);
        send_load(0, 1, 32'h0, 1'b0);
        send_load(0, 2, 32'hFFFF_FFFF, 1'b0);
        send_load(3, 0, 32'h0, 1'b0);
        send_load(1, 2, 32'h0001_0000, 1'b0);
        send_load(1, 3, 32'hFFFF_FFFF, 1'b0);
        send_load(2, 3, 32'h0, 1'b1);
        drain_run();
        write_leaf(31);
        load_matrix(31, 0);
        drain_run();

        set_no = 0;
        while (loads < 370) begin
            case (set_no % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 87; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 87; end
                default: begin idle_pct = 11; stall_pct = 11; end
            endcase
            r = $urandom_range(99);
            if (r < 4)       leaf = $urandom_range(1);
            else if (r < 70) leaf = $urandom_range(8, 2);
            else if (r < 86) leaf = $urandom_range(15, 9);
            else if (r < 94) leaf = 16;
            else             leaf = $urandom_range(31, 17);
            write_leaf(leaf);
            if (set_no == 3) long_hold = 1'b1;
            load_matrix(leaf, $urandom_range(2));
            // queue a second matrix behind the run while the receiver holds off
            if (set_no == 3) load_matrix(leaf, 1);
            drain_run();
            set_no++;
        end

        $display("covered %0d pair loads over %0d clustering runs, %0d merges compared",
                 loads, runs, merges);
        if (errors == 0) begin
            $display("[upgma_cluster_merge] OK");
        end else begin
            $display("[upgma_cluster_merge] ERROR");
        end
        $finish;
    end
endmodule

[files.f]
sv/ucm_pkg.sv
sv/ucm_if.sv
sv/ucm_ram.sv
sv/ucm_ctrl.sv
sv/ucm_dp.sv
sv/upgma_cluster_merge.sv
bench/upgma_cluster_merge_checker.sv
bench/upgma_cluster_merge_test.sv
